// ===== rtl/lse_pkg.sv =====
package lse_pkg;

  localparam int NumLeds  = 32;
  localparam int LedLimit = (NumLeds < 32) ? NumLeds : 32;
  localparam int AddrW    = $clog2(LedLimit);
  localparam int QDepth   = 2;
  localparam int QAddrW   = $clog2(QDepth);

  localparam logic [5:0] LastIdx     = 6'(LedLimit - 1);
  localparam logic [5:0] LimitCount  = 6'(LedLimit);
  localparam logic [4:0] BaseFade    = 5'd24;
  localparam logic [7:0] FullLevel   = 8'd255;
  localparam logic [7:0] MidLevel    = 8'd165;
  localparam logic [2:0] LastPalette = 3'd6;

  typedef enum logic [1:0] {
    MODE_STATIC  = 2'd0,
    MODE_RAINBOW = 2'd1,
    MODE_FLOW    = 2'd2,
    MODE_OFF     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_COUNT  = 2'd1,
    REG_DELAY  = 2'd2,
    REG_BRIGHT = 2'd3
  } reg_idx_t;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_SETUP = 2'd1,
    CMD_STEP  = 2'd2
  } cmd_kind_t;

  typedef enum logic [1:0] {
    PC_ZERO = 2'd0,
    PC_FULL = 2'd1,
    PC_MID  = 2'd2
  } pal_code_t;

  typedef struct packed {
    mode_t       mode;
    logic [5:0]  count;
    logic [15:0] delay;
    logic [7:0]  bright;
  } lse_cfg_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [4:0]  addr;
    logic [23:0] color;
  } lse_cmd_t;

  // floor(p / 255) for p up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] s;
    s = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
    return s[15:8];
  endfunction

  function automatic logic [7:0] approach(input logic [7:0] cur, input logic [7:0] tgt,
                                          input logic [4:0] step);
    logic [8:0] up;
    logic [7:0] c;
    c  = cur;
    up = {1'b0, c} + {4'd0, step};
    if (c < tgt) c = up[8] ? 8'hFF : up[7:0];
    if (c > tgt) c = (c > {3'd0, step}) ? c - {3'd0, step} : 8'h00;
    return c;
  endfunction

  // channel codes of the base palette, red first
  function automatic pal_code_t pal_code(input logic [2:0] idx, input logic [1:0] ch);
    pal_code_t r, g, b;
    case (idx)
      3'd0: begin r = PC_FULL; g = PC_ZERO; b = PC_ZERO; end
      3'd1: begin r = PC_FULL; g = PC_MID;  b = PC_ZERO; end
      3'd2: begin r = PC_FULL; g = PC_FULL; b = PC_ZERO; end
      3'd3: begin r = PC_ZERO; g = PC_FULL; b = PC_ZERO; end
      3'd4: begin r = PC_ZERO; g = PC_FULL; b = PC_FULL; end
      3'd5: begin r = PC_ZERO; g = PC_ZERO; b = PC_FULL; end
      3'd6: begin r = PC_FULL; g = PC_ZERO; b = PC_FULL; end
      default: begin r = PC_ZERO; g = PC_ZERO; b = PC_ZERO; end
    endcase
    case (ch)
      2'd0: return r;
      2'd1: return g;
      default: return b;
    endcase
  endfunction

endpackage

// ===== rtl/lse_queue.sv =====
module lse_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lse_pkg::lse_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output lse_pkg::lse_cmd_t head,
  output logic              empty
);
  import lse_pkg::*;

  lse_cmd_t            slots [QDepth];
  logic [QAddrW-1:0]   wr_ptr;
  logic [QAddrW-1:0]   rd_ptr;
  logic [QAddrW:0]     count;

  assign full  = (count == (QAddrW + 1)'(QDepth));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= (wr_ptr == QAddrW'(QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= (rd_ptr == QAddrW'(QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (QAddrW + 1)'(push && !full) - (QAddrW + 1)'(pop && !empty);
    end
  end

endmodule

// ===== rtl/lse_front.sv =====
module lse_front (
  input  logic              clk,
  input  logic              rst,
  input  lse_pkg::lse_cfg_t cfg,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [63:0]       s_tdata,
  input  logic              s_tuser,
  output logic              q_push,
  output lse_pkg::lse_cmd_t q_cmd,
  input  logic              q_full
);
  import lse_pkg::*;

  logic [31:0] deadline;
  logic        need_setup;
  logic        static_done;
  logic [30:0] now;
  logic [4:0]  led_index;
  logic        accept;
  logic        past;
  logic        step;

  assign now       = s_tdata[30:0];
  assign led_index = s_tdata[35:31];
  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;
  assign past      = deadline[31] || (deadline < {1'b0, now});
  assign step      = !need_setup && past && !static_done;

  always_comb begin
    q_cmd.addr  = led_index;
    q_cmd.color = s_tdata[59:36];
    q_cmd.kind  = CMD_STEP;
    q_push      = 1'b0;
    if (op_t'(s_tuser) == OP_WRITE) begin
      q_cmd.kind = CMD_WRITE;
      q_push     = accept && (7'(led_index) < 7'(NumLeds));
    end else if (need_setup) begin
      q_cmd.kind = CMD_SETUP;
      q_push     = accept;
    end else begin
      q_push = accept && step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deadline    <= '0;
      need_setup  <= 1'b1;
      static_done <= 1'b0;
    end else if (accept && op_t'(s_tuser) == OP_TICK) begin
      if (need_setup) begin
        need_setup <= 1'b0;
      end else if (step) begin
        deadline <= {1'b0, now} + {16'd0, cfg.delay};
        if (cfg.mode == MODE_STATIC) static_done <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/lse_back.sv =====
module lse_back (
  input  logic              clk,
  input  logic              rst,
  input  lse_pkg::lse_cfg_t cfg,
  input  logic              q_empty,
  input  lse_pkg::lse_cmd_t q_cmd,
  output logic              q_pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,
  output logic              m_tlast
);
  import lse_pkg::*;

  typedef enum logic [14:0] {
    ST_IDLE     = 15'b000000000000001,
    ST_CLR      = 15'b000000000000010,
    ST_SC_RD    = 15'b000000000000100,
    ST_SC_MUL   = 15'b000000000001000,
    ST_SC_WR    = 15'b000000000010000,
    ST_ZERO     = 15'b000000000100000,
    ST_TMP_RD   = 15'b000000001000000,
    ST_TMP_WAIT = 15'b000000010000000,
    ST_SH_RD    = 15'b000000100000000,
    ST_SH_WR    = 15'b000001000000000,
    ST_FL_WR    = 15'b000010000000000,
    ST_L0_RD    = 15'b000100000000000,
    ST_L0_WR    = 15'b001000000000000,
    ST_EM_RD    = 15'b010000000000000,
    ST_EM_OUT   = 15'b100000000000000
  } state_t;

  state_t      state;
  logic [5:0]  idx;
  logic [5:0]  n;
  logic [5:0]  nm1;
  logic [5:0]  idx_m1;
  logic [23:0] mem [LedLimit];
  logic [23:0] rdata;
  logic [23:0] tmp;
  logic [15:0] prod_r;
  logic [15:0] prod_g;
  logic [15:0] prod_b;
  logic [7:0]  pal_full;
  logic [7:0]  pal_mid;
  logic [4:0]  fade;
  logic [4:0]  hold;
  logic [5:0]  hold_next;
  logic [2:0]  pal_idx;
  logic        mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [23:0] mem_wdata;
  logic        mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic        out_free;
  logic        out_load;
  logic [23:0] out_color;
  logic        out_last;
  logic [15:0] mid_prod;
  logic [15:0] fade_prod;
  logic [7:0]  fade_scaled;
  logic [23:0] led0;
  logic [7:0]  tgt [3];

  always_comb begin
    n = cfg.count;
    if (n == 6'd0) n = 6'd1;
    if (n > LimitCount) n = LimitCount;
  end

  assign nm1         = n - 6'd1;
  assign idx_m1      = idx - 6'd1;
  assign hold_next   = {1'b0, hold} + 6'd1;
  assign out_free    = !m_tvalid || m_tready;
  assign mid_prod    = {8'd0, cfg.bright} * {8'd0, MidLevel};
  assign fade_prod   = {8'd0, cfg.bright} * {11'd0, BaseFade};
  assign fade_scaled = div255(fade_prod);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      case (pal_code(pal_idx, 2'(c)))
        PC_FULL: tgt[c] = pal_full;
        PC_MID:  tgt[c] = pal_mid;
        default: tgt[c] = 8'd0;
      endcase
    end
    led0[7:0]   = approach(rdata[7:0],   tgt[0], fade);
    led0[15:8]  = approach(rdata[15:8],  tgt[1], fade);
    led0[23:16] = approach(rdata[23:16], tgt[2], fade);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx[AddrW-1:0];
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = idx[AddrW-1:0];
    q_pop     = 1'b0;
    out_load  = 1'b0;
    out_color = '0;
    out_last  = 1'b0;
    case (state)
      ST_IDLE: begin
        q_pop = !q_empty;
        if (!q_empty && q_cmd.kind == CMD_WRITE) begin
          mem_we    = 1'b1;
          mem_waddr = q_cmd.addr[AddrW-1:0];
          mem_wdata = q_cmd.color;
        end
      end
      ST_CLR: mem_we = 1'b1;
      ST_SC_RD: mem_re = 1'b1;
      ST_SC_WR: begin
        mem_we    = 1'b1;
        mem_wdata = {div255(prod_b), div255(prod_g), div255(prod_r)};
      end
      ST_ZERO: begin
        out_load = out_free;
        out_last = (idx == LastIdx);
      end
      ST_TMP_RD: begin
        mem_re    = 1'b1;
        mem_raddr = nm1[AddrW-1:0];
      end
      ST_SH_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_m1[AddrW-1:0];
      end
      ST_SH_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rdata;
      end
      ST_FL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = tmp;
      end
      ST_L0_RD: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
      end
      ST_L0_WR: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = led0;
      end
      ST_EM_RD: mem_re = 1'b1;
      ST_EM_OUT: begin
        out_load  = out_free;
        out_color = rdata;
        out_last  = (idx == nm1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {3'd0, out_color, idx[4:0]};
      m_tlast <= out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SC_MUL) begin
      prod_r <= {8'd0, rdata[7:0]}   * {8'd0, cfg.bright};
      prod_g <= {8'd0, rdata[15:8]}  * {8'd0, cfg.bright};
      prod_b <= {8'd0, rdata[23:16]} * {8'd0, cfg.bright};
    end
    if (state == ST_TMP_WAIT) tmp <= rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      idx      <= '0;
      m_tvalid <= 1'b0;
      hold     <= '0;
      pal_idx  <= '0;
      pal_full <= FullLevel;
      pal_mid  <= MidLevel;
      fade     <= BaseFade;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            idx <= (q_cmd.kind == CMD_STEP && cfg.mode == MODE_RAINBOW) ? nm1 : 6'd0;
            case (q_cmd.kind)
              CMD_SETUP: begin
                case (cfg.mode)
                  MODE_RAINBOW: begin
                    pal_full <= cfg.bright;
                    pal_mid  <= div255(mid_prod);
                    fade     <= fade_scaled[4:0] + 5'd1;
                    state    <= ST_CLR;
                  end
                  MODE_STATIC, MODE_FLOW: state <= ST_SC_RD;
                  default: state <= ST_ZERO;
                endcase
              end
              CMD_STEP: begin
                case (cfg.mode)
                  MODE_RAINBOW: begin
                    if (hold_next > {2'd0, n[5:2]}) begin
                      hold    <= '0;
                      pal_idx <= (pal_idx == LastPalette) ? 3'd0 : pal_idx + 3'd1;
                    end else begin
                      hold <= hold_next[4:0];
                    end
                    state <= (nm1 != 6'd0) ? ST_SH_RD : ST_L0_RD;
                  end
                  MODE_FLOW: state <= ST_TMP_RD;
                  default: state <= ST_EM_RD;
                endcase
              end
              default: ;
            endcase
          end
        end
        ST_CLR: begin
          if (idx == LastIdx) begin
            idx   <= '0;
            state <= ST_ZERO;
          end else begin
            idx <= idx + 6'd1;
          end
        end
        ST_SC_RD: state <= ST_SC_MUL;
        ST_SC_MUL: state <= ST_SC_WR;
        ST_SC_WR: begin
          if (idx == nm1) begin
            idx   <= '0;
            state <= ST_ZERO;
          end else begin
            idx   <= idx + 6'd1;
            state <= ST_SC_RD;
          end
        end
        ST_ZERO: begin
          if (out_free) begin
            if (idx == LastIdx) state <= ST_IDLE;
            else idx <= idx + 6'd1;
          end
        end
        ST_TMP_RD: state <= ST_TMP_WAIT;
        ST_TMP_WAIT: begin
          idx   <= nm1;
          state <= (nm1 != 6'd0) ? ST_SH_RD : ST_FL_WR;
        end
        ST_SH_RD: state <= ST_SH_WR;
        ST_SH_WR: begin
          if (idx == 6'd1) begin
            state <= (cfg.mode == MODE_RAINBOW) ? ST_L0_RD : ST_FL_WR;
          end else begin
            idx   <= idx_m1;
            state <= ST_SH_RD;
          end
        end
        ST_FL_WR: begin
          idx   <= '0;
          state <= ST_EM_RD;
        end
        ST_L0_RD: state <= ST_L0_WR;
        ST_L0_WR: begin
          idx   <= '0;
          state <= ST_EM_RD;
        end
        ST_EM_RD: state <= ST_EM_OUT;
        ST_EM_OUT: begin
          if (out_free) begin
            if (idx == nm1) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx + 6'd1;
              state <= ST_EM_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EM_OUT) |-> (idx < n))
    else $error("frame index beyond active LED count");

  a_zero_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ZERO) |-> (idx <= LastIdx))
    else $error("set-up frame index beyond strip length");

  a_start_needs_pop: assert property (@(posedge clk) disable iff (rst)
    ($past(state == ST_IDLE) && state != ST_IDLE) |-> $past(q_pop))
    else $error("back end left idle without a command");

endmodule

// ===== rtl/led_strip_effect_engine_unit.sv =====
// LED strip effect engine.
// Input stream (s_*): one beat per item. s_tuser is the op (0 tick, 1 colour write);
// a write stores red/green/blue at led_index, a tick carries time_ms. The first tick
// emits an all-black frame of 32 pixels after the set-up work; later ticks past the
// deadline step the effect (only once in static mode) and emit one active-count frame.
// Output stream (m_*): one pixel per beat, m_tlast on the final pixel of a frame.
// Configuration channel (cfg_*): index 0 mode, 1 LED count, 2 frame delay,
// 3 brightness; always ready; user writes only while engine idle, block does not enforce.
// The colour store has one read and one write port, so work is serial: a write item
// is stored from idle; a rainbow set-up clears all 32 colours, a static/flow set-up
// scales each active LED by brightness, both before the black frame; a flow/rainbow
// step shifts the LEDs one place, and every step then reads and emits each active pixel.
// A two-entry command queue lets input beats be taken while a frame is still out.
// Reset clears control state and the queue; store contents stay undefined until written.
// When the receiver stalls, the output register holds its beat and the frame pauses;
// the queue then fills and s_tready drops.
module led_strip_effect_engine_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // time_ms, led_index, red_in, green_in, blue_in, zero pad
  input  logic        s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // pixel_index, red_out, green_out, blue_out, zero pad
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import lse_pkg::*;

  lse_cfg_t cfg;
  lse_cmd_t push_cmd;
  lse_cmd_t head;
  logic     push;
  logic     full;
  logic     pop;
  logic     empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode   <= MODE_STATIC;
      cfg.count  <= 6'd32;
      cfg.delay  <= '0;
      cfg.bright <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_MODE:   cfg.mode   <= mode_t'(cfg_data[1:0]);
        REG_COUNT:  cfg.count  <= cfg_data[5:0];
        REG_DELAY:  cfg.delay  <= cfg_data;
        REG_BRIGHT: cfg.bright <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  lse_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_push   (push),
    .q_cmd    (push_cmd),
    .q_full   (full)
  );

  lse_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  lse_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (empty),
    .q_cmd    (head),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
